>>> rtl/spl_pkg.sv
// Shared constants, register codes, stage numbers and carry types of the sponge source block.
`default_nettype none
package spl_pkg;

  // erf lookup table
  localparam int SplErfDepth = 1024;
  localparam int SplErfW     = 17;    // entries are 0 .. 65536

  // configuration register codes
  localparam int CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] RegBoxLow   = 8'd0;
  localparam logic [CfgIdxW-1:0] RegBoxHigh  = 8'd1;
  localparam logic [CfgIdxW-1:0] RegDomLow   = 8'd2;
  localparam logic [CfgIdxW-1:0] RegDomHigh  = 8'd3;
  localparam logic [CfgIdxW-1:0] RegRefMass  = 8'd4;
  localparam logic [CfgIdxW-1:0] RegRefMomE  = 8'd5;
  localparam logic [CfgIdxW-1:0] RegRate     = 8'd6;
  localparam logic [CfgIdxW-1:0] RegInvHalfW = 8'd7;

  localparam logic [30:0] InvHalfWRst = 31'd131072;

  // pipeline stage numbers
  localparam int StIn      = 0;   // input capture
  localparam int StDiff    = 1;   // offsets from ramp centres, state deltas
  localparam int StProd    = 2;   // |offset| * k
  localparam int StIdx     = 3;   // table index
  localparam int StRom     = 4;   // table data
  localparam int StWgt     = 5;   // |2w| * rate
  localparam int StDtp     = 6;   // partial products with dt
  localparam int StCoef    = 7;   // coefficient
  localparam int StDmp     = 8;   // partial products with |delta|
  localparam int StTerm    = 9;   // signed region terms
  localparam int StOut     = 10;  // accumulate and saturate
  localparam int NumStages = 11;

  localparam int TermW = 49;

  // side data that travels down the pipeline next to the region units
  typedef struct packed {
    logic [31:0]       dt;
    logic [3:0][32:0]  diff;   // state minus reference, signed
    logic [3:0][31:0]  src;
    logic [3:0]        act;    // left, right, bottom, top
    logic [3:0]        sh2;    // corner: one extra halving
  } spl_carry_t;

  typedef struct packed {
    logic high_side;
    logic act_s4;
    logic sh2_s8;
  } spl_rgn_ctl_t;

endpackage
`default_nettype wire

>>> rtl/spl_ifs.sv
// Channel interfaces of the sponge source block: cell input, damped result, register writes.
`default_nettype none
interface spl_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cell_x;
  logic signed [31:0] cell_y;
  logic signed [31:0] density;
  logic signed [31:0] momentum_x;
  logic signed [31:0] momentum_y;
  logic signed [31:0] energy;
  logic [31:0]        step_dt;
  logic signed [31:0] source_in_density;
  logic signed [31:0] source_in_momentum_x;
  logic signed [31:0] source_in_momentum_y;
  logic signed [31:0] source_in_energy;

  modport source (
    output valid, cell_x, cell_y, density, momentum_x, momentum_y, energy, step_dt,
           source_in_density, source_in_momentum_x, source_in_momentum_y,
           source_in_energy,
    input  ready
  );
  modport sink (
    input  valid, cell_x, cell_y, density, momentum_x, momentum_y, energy, step_dt,
           source_in_density, source_in_momentum_x, source_in_momentum_y,
           source_in_energy,
    output ready
  );
endinterface

interface spl_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] source_density;
  logic signed [31:0] source_momentum_x;
  logic signed [31:0] source_momentum_y;
  logic signed [31:0] source_energy;

  modport source (
    output valid, source_density, source_momentum_x, source_momentum_y, source_energy,
    input  ready
  );
  modport sink (
    input  valid, source_density, source_momentum_x, source_momentum_y, source_energy,
    output ready
  );
endinterface

interface spl_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/spl_erf_rom.sv
// erf lookup ROM, contents integrated at elaboration, two registered read ports.
`default_nettype none
module spl_erf_rom import spl_pkg::*; #(
  parameter int Depth = SplErfDepth,
  parameter int AW    = $clog2(Depth)
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [AW-1:0]      addr_a,
  input  logic [AW-1:0]      addr_b,
  output logic [SplErfW-1:0] data_a,
  output logic [SplErfW-1:0] data_b
);

  localparam logic [63:0] One       = 64'h4000_0000_0000_0000;
  localparam logic [63:0] TwoSqrtPi = 64'd1211587905;   // 2/sqrt(pi), Q30

  // integration grid: Sub steps per entry, N steps over [0,4], step^2 in Q62
  localparam int          Sub = (4096 + Depth - 1) / Depth;
  localparam logic [63:0] N   = 64'(Depth) * 64'(Sub);
  localparam logic [63:0] Eps = ((64'h1 << 63) / (N * N)) << 3;

  function automatic logic [63:0] mul62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    logic [127:0] q;
    p = {64'd0, a} * {64'd0, b};
    q = p >> 62;
    if (q > {64'd0, One}) return One;
    return q[63:0];
  endfunction

  function automatic logic [63:0] exp_small(input logic [63:0] e);
    logic [63:0] e2;
    logic [63:0] e3;
    e2 = mul62(e, e);
    e3 = mul62(e2, e);
    return One - e + e2 / 64'd2 - e3 / 64'd6;
  endfunction

  // trapezoid integration of exp(-t^2) over [0,4], one entry every Sub steps
  function automatic logic [Depth*SplErfW-1:0] build_rom();
    logic [Depth*SplErfW-1:0] tab;
    logic [63:0] r, q, g, g0, sum, gs, t, v, e;
    int cnt, ent;
    tab = '0;
    r   = exp_small(Eps);
    q   = exp_small(Eps << 1);
    g   = One;
    g0  = One >> 20;
    sum = '0;
    cnt = 0;
    ent = 0;
    for (int i = 0; i < int'(N); i++) begin
      gs  = g >> 20;
      sum = sum + gs;
      if (cnt == 0) begin
        t = sum - ((g0 + gs) >> 1);
        v = ((t << 2) / N) >> 10;
        e = (v * TwoSqrtPi + (64'h1 << 45)) >> 46;
        if (e > 64'd65536) e = 64'd65536;
        tab[ent*SplErfW +: SplErfW] = e[SplErfW-1:0];
        ent = ent + 1;
      end
      cnt = (cnt == Sub - 1) ? 0 : cnt + 1;
      g = mul62(g, r);
      r = mul62(r, q);
    end
    return tab;
  endfunction

  localparam logic [Depth*SplErfW-1:0] RomBits = build_rom();

  logic [SplErfW-1:0] data_a_r;
  logic [SplErfW-1:0] data_b_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_a_r <= RomBits[int'(addr_a)*SplErfW +: SplErfW];
      data_b_r <= RomBits[int'(addr_b)*SplErfW +: SplErfW];
    end
  end

  assign data_a = data_a_r;
  assign data_b = data_b_r;

endmodule
`default_nettype wire

>>> rtl/spl_region.sv
// One sponge edge region: erf ramp weight and the four damping terms, stages 1 to 9.
`default_nettype none
module spl_region import spl_pkg::*; #(
  parameter int Depth = SplErfDepth
) (
  input  logic                       clk,
  input  logic [NumStages-1:0]       en,
  input  spl_rgn_ctl_t               ctl,
  input  logic signed [31:0]         pos,       // stage 0
  input  logic signed [31:0]         bnd,       // box edge
  input  logic signed [31:0]         dom,       // domain edge
  input  logic [30:0]                inv_hw,
  input  logic [30:0]                rate,
  input  logic [31:0]                dt_s5,
  input  logic [3:0][32:0]           diff_s7,
  output logic [3:0][TermW-1:0]      term
);

  localparam int AW  = $clog2(Depth);
  localparam int IMW = 20 + AW;   // a * Depth + half

  // stage 1: offsets of cell and box edge from the ramp centre
  logic signed [32:0] span;
  logic signed [32:0] ctr;
  logic signed [33:0] dc_nxt, de_nxt;
  logic signed [33:0] dc_r, de_r;

  always_comb begin
    span   = 33'(dom) - 33'(bnd);
    ctr    = 33'(bnd) + (span >>> 1);
    dc_nxt = 34'(pos) - 34'(ctr);
    de_nxt = 34'(bnd) - 34'(ctr);
  end

  always_ff @(posedge clk) begin
    if (en[StDiff]) begin
      dc_r <= dc_nxt;
      de_r <= de_nxt;
    end
  end

  // stage 2: |offset| * k
  logic [33:0] mc, me;
  logic [63:0] pc_nxt, pe_nxt, pc_r, pe_r;
  logic        nc2_r, ne2_r;

  always_comb begin
    mc     = dc_r[33] ? 34'(-dc_r) : 34'(dc_r);
    me     = de_r[33] ? 34'(-de_r) : 34'(de_r);
    pc_nxt = 64'(mc[32:0]) * 64'(inv_hw);
    pe_nxt = 64'(me[32:0]) * 64'(inv_hw);
  end

  always_ff @(posedge clk) begin
    if (en[StProd]) begin
      pc_r  <= pc_nxt;
      pe_r  <= pe_nxt;
      nc2_r <= dc_r[33];
      ne2_r <= de_r[33];
    end
  end

  // stage 3: clamp to 4.0, round to a table index
  function automatic logic [AW-1:0] to_index(input logic [63:0] p);
    logic [18:0]    a;
    logic [IMW-1:0] m;
    logic [IMW-1:0] idx;
    a   = (p[63:16] > 48'h40000) ? 19'h40000 : p[34:16];
    m   = IMW'(a) * IMW'(Depth) + IMW'(32'h20000);
    idx = m >> 18;
    if (idx >= IMW'(Depth)) return AW'(Depth - 1);
    return idx[AW-1:0];
  endfunction

  logic [AW-1:0] ic_r, ie_r;
  logic          nc3_r, ne3_r;

  always_ff @(posedge clk) begin
    if (en[StIdx]) begin
      ic_r  <= to_index(pc_r);
      ie_r  <= to_index(pe_r);
      nc3_r <= nc2_r;
      ne3_r <= ne2_r;
    end
  end

  // stage 4: table read
  logic [SplErfW-1:0] rom_c, rom_e;
  logic               nc4_r, ne4_r;

  spl_erf_rom #(.Depth(Depth), .AW(AW)) u_rom (
    .clk    (clk),
    .rd_en  (en[StRom]),
    .addr_a (ic_r),
    .addr_b (ie_r),
    .data_a (rom_c),
    .data_b (rom_e)
  );

  always_ff @(posedge clk) begin
    if (en[StRom]) begin
      nc4_r <= nc3_r;
      ne4_r <= ne3_r;
    end
  end

  // stage 5: 2w and |2w| * rate
  logic signed [17:0] ec, eb;
  logic signed [18:0] w2;
  logic [18:0]        wmag;
  logic [47:0]        wp_nxt, wp_r;
  logic               wneg5_r;

  always_comb begin
    ec     = nc4_r ? -$signed({1'b0, rom_c}) : $signed({1'b0, rom_c});
    eb     = ne4_r ? -$signed({1'b0, rom_e}) : $signed({1'b0, rom_e});
    w2     = ctl.high_side ? (19'(ec) - 19'(eb)) : (19'(eb) - 19'(ec));
    wmag   = w2[18] ? 19'(-w2) : 19'(w2);
    wp_nxt = ctl.act_s4 ? (48'(wmag[17:0]) * 48'(rate)) : '0;
  end

  always_ff @(posedge clk) begin
    if (en[StWgt]) begin
      wp_r    <= wp_nxt;
      wneg5_r <= w2[18];
    end
  end

  // stage 6: two partial products with dt
  logic [55:0] ph_r, pl_r;
  logic        wneg6_r;

  always_ff @(posedge clk) begin
    if (en[StDtp]) begin
      ph_r    <= 56'(wp_r[47:24]) * 56'(dt_s5);
      pl_r    <= 56'(wp_r[23:0]) * 56'(dt_s5);
      wneg6_r <= wneg5_r;
    end
  end

  // stage 7: coefficient, 32 fraction bits dropped
  logic [79:0] cfull;
  logic [47:0] coef_r;
  logic        wneg7_r;

  assign cfull = (80'(ph_r) << 24) + 80'(pl_r);

  always_ff @(posedge clk) begin
    if (en[StCoef]) begin
      coef_r  <= cfull[79:32];
      wneg7_r <= wneg6_r;
    end
  end

  // stage 8: coefficient times |delta|, split in two
  logic [3:0][31:0] dm;
  logic [3:0][55:0] mh_r, ml_r;
  logic [3:0]       neg8_r;

  always_comb begin
    for (int v = 0; v < 4; v++) begin
      dm[v] = diff_s7[v][32] ? 32'(-$signed(diff_s7[v])) : diff_s7[v][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[StDmp]) begin
      for (int v = 0; v < 4; v++) begin
        mh_r[v]   <= 56'(coef_r[47:24]) * 56'(dm[v]);
        ml_r[v]   <= 56'(coef_r[23:0]) * 56'(dm[v]);
        neg8_r[v] <= wneg7_r ^ diff_s7[v][32];
      end
    end
  end

  // stage 9: scale to Q16.16 (half of 2w, and half again in a corner), sign
  logic [3:0][79:0] mfull;
  logic [3:0][79:0] msh;
  logic [3:0][TermW-1:0] term_nxt, term_r;

  always_comb begin
    for (int v = 0; v < 4; v++) begin
      mfull[v]    = (80'(mh_r[v]) << 24) + 80'(ml_r[v]);
      msh[v]      = ctl.sh2_s8 ? (mfull[v] >> 34) : (mfull[v] >> 33);
      term_nxt[v] = neg8_r[v] ? TermW'(-$signed({1'b0, msh[v][47:0]}))
                              : TermW'({1'b0, msh[v][47:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (en[StTerm]) begin
      term_r <= term_nxt;
    end
  end

  assign term = term_r;

endmodule
`default_nettype wire

>>> rtl/sponge_layer_source_term.sv
// Top level of the sponge-layer source damping block: registers, pipeline control, output sum.
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    cell x/y, conserved state, dt, four incoming sources
//  out_ch   out  valid/ready    four damped sources, saturated Q16.16
//  cfg_ch   in   valid/ready    8-bit register index, 64-bit data
//
// Eleven register stages, from input capture to the output register; one cell per cycle
// is sustained while out_ch is ready. The depth is set by the multiply chain
// |2w| * rate * dt * |delta|, cut into 24-bit partial products, plus the ROM read.
// Each stage has its own valid bit and moves whenever the next one is empty or moving,
// so bubbles close up under an output stall and nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears stage valids and the configuration registers,
// but sets the inverse half width to InvHalfWRst. The configuration port is always ready.
`default_nettype none
module sponge_layer_source_term import spl_pkg::*; #(
  parameter int ErfDepth = SplErfDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  spl_in_if.sink     in_ch,
  spl_out_if.source  out_ch,
  spl_cfg_if.sink    cfg_ch
);

  // ---------------------------------------------------------------- config
  logic [63:0] box_low_r, box_high_r, dom_low_r, dom_high_r, ref_mm_r, ref_me_r;
  logic [30:0] rate_r, inv_hw_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_low_r  <= '0;
      box_high_r <= '0;
      dom_low_r  <= '0;
      dom_high_r <= '0;
      ref_mm_r   <= '0;
      ref_me_r   <= '0;
      rate_r     <= '0;
      inv_hw_r   <= InvHalfWRst;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        RegBoxLow:   box_low_r  <= cfg_ch.data;
        RegBoxHigh:  box_high_r <= cfg_ch.data;
        RegDomLow:   dom_low_r  <= cfg_ch.data;
        RegDomHigh:  dom_high_r <= cfg_ch.data;
        RegRefMass:  ref_mm_r   <= cfg_ch.data;
        RegRefMomE:  ref_me_r   <= cfg_ch.data;
        RegRate:     rate_r     <= cfg_ch.data[30:0];
        RegInvHalfW: inv_hw_r   <= cfg_ch.data[30:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  // rdy[s]: stage s may load this cycle. Chain runs back from the output.
  logic [NumStages-1:0] v_r, v_nxt, rdy;

  always_comb begin
    rdy[StOut] = !v_r[StOut] || out_ch.ready;
    for (int s = StOut - 1; s >= 0; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
    v_nxt[StIn] = rdy[StIn] ? in_ch.valid : v_r[StIn];
    for (int s = 1; s < NumStages; s++) begin
      v_nxt[s] = rdy[s] ? v_r[s-1] : v_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready = rdy[StIn];

  // ---------------------------------------------------------------- stage 0: capture
  logic signed [31:0]       x_r, y_r;
  logic [3:0][31:0]         st_r, src_r;
  logic [31:0]              dt_r;

  always_ff @(posedge clk) begin
    if (rdy[StIn]) begin
      x_r      <= in_ch.cell_x;
      y_r      <= in_ch.cell_y;
      st_r[0]  <= in_ch.density;
      st_r[1]  <= in_ch.momentum_x;
      st_r[2]  <= in_ch.momentum_y;
      st_r[3]  <= in_ch.energy;
      dt_r     <= in_ch.step_dt;
      src_r[0] <= in_ch.source_in_density;
      src_r[1] <= in_ch.source_in_momentum_x;
      src_r[2] <= in_ch.source_in_momentum_y;
      src_r[3] <= in_ch.source_in_energy;
    end
  end

  // ---------------------------------------------------------------- stage 1: regions, deltas
  logic [3:0][31:0] ref_v;
  logic             left, right, bottom, top_s, xside, yside;
  spl_carry_t       car_nxt;
  spl_carry_t       car_r [StDiff:StTerm];

  always_comb begin
    ref_v[0] = ref_mm_r[63:32];
    ref_v[1] = ref_mm_r[31:0];
    ref_v[2] = ref_me_r[63:32];
    ref_v[3] = ref_me_r[31:0];

    // region tests as written: a reversed box can put a cell in both sides
    left   = x_r <= $signed(box_low_r[63:32]);
    right  = x_r >= $signed(box_high_r[63:32]);
    bottom = y_r <= $signed(box_low_r[31:0]);
    top_s  = y_r >= $signed(box_high_r[31:0]);
    xside  = left || right;
    yside  = bottom || top_s;

    car_nxt.dt  = dt_r;
    car_nxt.src = src_r;
    car_nxt.act = {top_s, bottom, right, left};
    // corner cells: each term takes half again
    car_nxt.sh2 = {xside, xside, yside, yside};
    for (int v = 0; v < 4; v++) begin
      car_nxt.diff[v] = 33'($signed(st_r[v])) - 33'($signed(ref_v[v]));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[StDiff]) car_r[StDiff] <= car_nxt;
    for (int s = StDiff + 1; s <= StTerm; s++) begin
      if (rdy[s]) car_r[s] <= car_r[s-1];
    end
  end

  // ---------------------------------------------------------------- region units
  // 0 left (x), 1 right (x), 2 bottom (y), 3 top (y)
  logic signed [31:0]    rg_pos [4];
  logic signed [31:0]    rg_bnd [4];
  logic signed [31:0]    rg_dom [4];
  logic [3:0][TermW-1:0] rg_term [4];
  spl_rgn_ctl_t          rg_ctl [4];

  always_comb begin
    rg_pos[0] = x_r;
    rg_pos[1] = x_r;
    rg_pos[2] = y_r;
    rg_pos[3] = y_r;
    rg_bnd[0] = box_low_r[63:32];
    rg_bnd[1] = box_high_r[63:32];
    rg_bnd[2] = box_low_r[31:0];
    rg_bnd[3] = box_high_r[31:0];
    rg_dom[0] = dom_low_r[63:32];
    rg_dom[1] = dom_high_r[63:32];
    rg_dom[2] = dom_low_r[31:0];
    rg_dom[3] = dom_high_r[31:0];
    for (int r = 0; r < 4; r++) begin
      rg_ctl[r].high_side = (r == 1) || (r == 3);
      rg_ctl[r].act_s4    = car_r[StRom].act[r];
      rg_ctl[r].sh2_s8    = car_r[StDmp].sh2[r];
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_rgn
    spl_region #(.Depth(ErfDepth)) u_rgn (
      .clk     (clk),
      .en      (rdy),
      .ctl     (rg_ctl[r]),
      .pos     (rg_pos[r]),
      .bnd     (rg_bnd[r]),
      .dom     (rg_dom[r]),
      .inv_hw  (inv_hw_r),
      .rate    (rate_r),
      .dt_s5   (car_r[StWgt].dt),
      .diff_s7 (car_r[StCoef].diff),
      .term    (rg_term[r])
    );
  end

  // ---------------------------------------------------------------- stage 10: sum, saturate
  logic signed [51:0] acc [4];
  logic [3:0][31:0]   out_nxt, out_r;

  always_comb begin
    for (int v = 0; v < 4; v++) begin
      acc[v] = 52'($signed(car_r[StTerm].src[v]))
             - 52'($signed(rg_term[0][v])) - 52'($signed(rg_term[1][v]))
             - 52'($signed(rg_term[2][v])) - 52'($signed(rg_term[3][v]));
      if (acc[v] > 52'sd2147483647) begin
        out_nxt[v] = 32'h7fff_ffff;
      end else if (acc[v] < -52'sd2147483648) begin
        out_nxt[v] = 32'h8000_0000;
      end else begin
        out_nxt[v] = acc[v][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[StOut]) out_r <= out_nxt;
  end

  assign out_ch.valid             = v_r[StOut];
  assign out_ch.source_density    = out_r[0];
  assign out_ch.source_momentum_x = out_r[1];
  assign out_ch.source_momentum_y = out_r[2];
  assign out_ch.source_energy     = out_r[3];

`ifndef SYNTH
  // input held off only when every stage holds a cell
  a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v_r == {NumStages{1'b1}}))
    else $error("input stalled with a bubble in the pipeline");

  // a finished term always reaches the output register
  a_term_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[StTerm] && rdy[StOut] |=> v_r[StOut])
    else $error("cell dropped between term and output stage");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (v_r == '0))
    else $error("stage valid survived reset");
`endif

endmodule
`default_nettype wire
